/* src/rit_pkg.sv */
// types, codes and constants shared by the repeat-init ignore table
// no dependencies
`timescale 1ns / 1ps

package rit_pkg;

    localparam int CNT_W = 7;
    localparam int THR_W = 6;
    localparam logic [THR_W-1:0] THR_RESET = 6'd10;

    typedef enum logic [1:0] {
        CMD_ROUND   = 2'd0,
        CMD_QUERY   = 2'd1,
        CMD_ATTEMPT = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_UPDATE,
        ST_DONE
    } t_state;

    typedef enum logic {
        OP_ROLL,
        OP_ATTEMPT
    } t_op;

    typedef struct packed {
        logic             cur;
        logic             prev;
        logic [CNT_W-1:0] count;
        logic             ignored;
    } t_marks;

    typedef struct packed {
        t_marks marks;
        logic   allowed;
        logic   newly;
        logic   keep;
    } t_alu_res;

    typedef struct packed {
        logic table_full;
        logic newly_ignored;
        logic good_for_init;
        logic init_allowed;
    } t_result;

endpackage

/* src/rit_mem.sv */
// entry store: key and mark memories with registered read, valid bits in flops
// depends on rit_pkg
`timescale 1ns / 1ps

module rit_mem #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    output logic [KEY_BITS-1:0]        o_rd_key,
    output rit_pkg::t_marks            o_rd_marks,
    output logic                       o_rd_valid,
    input  logic                       i_wr_en,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  logic [KEY_BITS-1:0]        i_wr_key,
    input  rit_pkg::t_marks            i_wr_marks,
    input  logic                       i_wr_valid
);
    import rit_pkg::*;

    logic [KEY_BITS-1:0] mem_key   [ENTRIES];
    t_marks              mem_marks [ENTRIES];
    logic [ENTRIES-1:0]  r_valid;
    logic [KEY_BITS-1:0] r_rd_key;
    t_marks              r_rd_marks;
    logic                r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_key[i_wr_addr]   <= i_wr_key;
            mem_marks[i_wr_addr] <= i_wr_marks;
        end
        r_rd_key   <= mem_key[i_rd_addr];
        r_rd_marks <= mem_marks[i_rd_addr];
        r_rd_valid <= r_valid[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= i_wr_valid;
        end
    end

    assign o_rd_key   = r_rd_key;
    assign o_rd_marks = r_rd_marks;
    assign o_rd_valid = r_rd_valid;

endmodule

/* src/rit_alu.sv */
// shared key compare and mark update unit, used for every entry visit
// depends on rit_pkg
`timescale 1ns / 1ps

module rit_alu #(
    parameter int KEY_BITS = 32
) (
    input  rit_pkg::t_op                 i_op,
    input  logic [KEY_BITS-1:0]          i_key_a,
    input  logic [KEY_BITS-1:0]          i_key_b,
    input  rit_pkg::t_marks              i_marks,
    input  logic [rit_pkg::THR_W-1:0]    i_thr,
    output logic                         o_match,
    output rit_pkg::t_alu_res            o_res
);
    import rit_pkg::*;

    logic [CNT_W-1:0] thr_ext;
    logic [CNT_W-1:0] cnt_inc;

    assign o_match = (i_key_a == i_key_b);
    assign thr_ext = {1'b0, i_thr};
    assign cnt_inc = i_marks.count + 1'b1;

    always_comb begin
        o_res         = '0;
        o_res.marks   = i_marks;
        o_res.keep    = 1'b1;
        case (i_op)
            OP_ROLL: begin
                o_res.marks.prev = i_marks.cur;
                o_res.marks.cur  = 1'b0;
                if (!i_marks.cur) begin
                    o_res.marks.count = '0;
                end
                // entries not seen last round are released unless ignored
                o_res.keep = i_marks.cur || i_marks.ignored;
            end
            OP_ATTEMPT: begin
                o_res.marks.cur = 1'b1;
                if (!i_marks.prev) begin
                    o_res.marks.count = '0;
                    o_res.allowed     = 1'b1;
                end else if (i_marks.count > thr_ext) begin
                    o_res.allowed = 1'b0;
                end else begin
                    o_res.marks.count = cnt_inc;
                    if (cnt_inc == thr_ext) begin
                        o_res.marks.ignored = 1'b1;
                        o_res.newly         = 1'b1;
                    end else begin
                        o_res.allowed = 1'b1;
                    end
                end
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

/* src/repeat_init_ignore_table.sv */
// repeat-init ignore table top level: sequencer, threshold register, output register
// cmd 0 sweeps and cmd 1 and 2 scan every entry before o_m_axis_tvalid, one entry visited per
// cycle through the single table read port; cmd 3 goes straight to the result
// one request is worked at a time: tready is low while one is worked and while a result
// waits on a stalled output
// reset: synchronous, active low; clears all valid bits at once and sets threshold to 10
`timescale 1ns / 1ps

module repeat_init_ignore_table #(
    parameter int TABLE_ENTRIES = 16,
    parameter int KEY_BITS      = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [39:0]               i_s_axis_tdata,  // cmd[1:0], device_key[33:2], zero pad
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [7:0]                o_m_axis_tdata,  // init_allowed, good_for_init,
                                                       // newly_ignored, table_full, zero pad
    input  logic                      i_cfg_we,
    input  logic [rit_pkg::THR_W-1:0] i_cfg_wdata
);
    import rit_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] IDX_END  = CW'(TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    t_state              r_state, n_state;
    logic [THR_W-1:0]    r_thr;
    t_cmd                r_cmd, n_cmd;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_pv, n_pv;
    logic [IW-1:0]       r_pidx, n_pidx;
    logic                r_found, n_found;
    logic [IW-1:0]       r_hit_idx, n_hit_idx;
    t_marks              r_hit_marks, n_hit_marks;
    logic                r_free_ok, n_free_ok;
    logic [IW-1:0]       r_free_idx, n_free_idx;
    t_result             r_res, n_res;
    logic                r_m_valid, n_m_valid;
    t_result             r_m_data, n_m_data;

    logic [63:0]         key_wide;
    logic [KEY_BITS-1:0] key_in;
    logic                accept;

    logic [IW-1:0]       rd_addr;
    logic [KEY_BITS-1:0] rd_key;
    t_marks              rd_marks;
    logic                rd_valid;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [KEY_BITS-1:0] wr_key;
    t_marks              wr_marks;
    logic                wr_valid;

    t_op                 alu_op;
    logic [KEY_BITS-1:0] alu_key_b;
    t_marks              alu_marks;
    logic                alu_match;
    t_alu_res            alu_res;

    assign key_wide = {32'd0, i_s_axis_tdata[33:2]};
    assign key_in   = key_wide[KEY_BITS-1:0];
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;

    rit_mem #(
        .ENTRIES  (TABLE_ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (rd_addr),
        .o_rd_key   (rd_key),
        .o_rd_marks (rd_marks),
        .o_rd_valid (rd_valid),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_key   (wr_key),
        .i_wr_marks (wr_marks),
        .i_wr_valid (wr_valid)
    );

    rit_alu #(
        .KEY_BITS (KEY_BITS)
    ) u_alu (
        .i_op    (alu_op),
        .i_key_a (r_key),
        .i_key_b (alu_key_b),
        .i_marks (alu_marks),
        .i_thr   (r_thr),
        .o_match (alu_match),
        .o_res   (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_thr     <= THR_RESET;
            r_pv      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pv      <= n_pv;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_key       <= n_key;
        r_idx       <= n_idx;
        r_pidx      <= n_pidx;
        r_found     <= n_found;
        r_hit_idx   <= n_hit_idx;
        r_hit_marks <= n_hit_marks;
        r_free_ok   <= n_free_ok;
        r_free_idx  <= n_free_idx;
        r_res       <= n_res;
        r_m_data    <= n_m_data;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_idx       = r_idx;
        n_pv        = 1'b0;
        n_pidx      = r_pidx;
        n_found     = r_found;
        n_hit_idx   = r_hit_idx;
        n_hit_marks = r_hit_marks;
        n_free_ok   = r_free_ok;
        n_free_idx  = r_free_idx;
        n_res       = r_res;
        n_m_valid   = r_m_valid && !i_m_axis_tready;
        n_m_data    = r_m_data;

        o_s_axis_tready = 1'b0;
        rd_addr   = r_idx[IW-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_pidx;
        wr_key    = rd_key;
        wr_marks  = alu_res.marks;
        wr_valid  = alu_res.keep;
        alu_op    = OP_ATTEMPT;
        alu_key_b = rd_key;
        alu_marks = rd_marks;

        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_cmd     = t_cmd'(i_s_axis_tdata[1:0]);
                    n_key     = key_in;
                    n_idx     = '0;
                    n_found   = 1'b0;
                    n_free_ok = 1'b0;
                    n_res     = '0;
                    case (t_cmd'(i_s_axis_tdata[1:0]))
                        CMD_ROUND:   n_state = ST_SWEEP;
                        CMD_QUERY:   n_state = ST_SCAN;
                        CMD_ATTEMPT: n_state = ST_SCAN;
                        default:     n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN, ST_SWEEP: begin
                if (r_state == ST_SWEEP) begin
                    alu_op = OP_ROLL;
                end
                // issue one read a cycle, check it the cycle after
                if (r_idx != IDX_END) begin
                    n_idx  = r_idx + 1'b1;
                    n_pv   = 1'b1;
                    n_pidx = r_idx[IW-1:0];
                end
                if (r_pv) begin
                    if (r_state == ST_SCAN) begin
                        if (rd_valid && alu_match && !r_found) begin
                            n_found     = 1'b1;
                            n_hit_idx   = r_pidx;
                            n_hit_marks = rd_marks;
                        end
                        if (!rd_valid && !r_free_ok) begin
                            n_free_ok  = 1'b1;
                            n_free_idx = r_pidx;
                        end
                    end else if (rd_valid) begin
                        wr_en = 1'b1;
                    end
                    if (r_pidx == LAST_IDX) begin
                        n_pv    = 1'b0;
                        n_state = (r_state == ST_SCAN) ? ST_UPDATE : ST_DONE;
                    end
                end
            end
            ST_UPDATE: begin
                alu_op    = OP_ATTEMPT;
                alu_key_b = r_key;
                alu_marks = r_found ? r_hit_marks : t_marks'('0);
                if (r_cmd == CMD_QUERY) begin
                    n_res.good_for_init = !(r_found && r_hit_marks.ignored);
                end else if (!r_found && !r_free_ok) begin
                    // no room: allow without storing
                    n_res.init_allowed = 1'b1;
                    n_res.table_full   = 1'b1;
                end else begin
                    wr_en    = 1'b1;
                    wr_addr  = r_found ? r_hit_idx : r_free_idx;
                    wr_key   = r_key;
                    wr_valid = 1'b1;
                    n_res.init_allowed  = alu_res.allowed;
                    n_res.newly_ignored = alu_res.newly;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = r_res;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {4'd0, r_m_data};

`ifndef SYNTHESIS
    a_newly_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[2] && o_m_axis_tdata[0]))
        else $error("newly ignored request was allowed");

    a_full_allows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[3]) |-> o_m_axis_tdata[0])
        else $error("full table request not allowed");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[1] && (o_m_axis_tdata[0] || o_m_axis_tdata[2])))
        else $error("query and attempt fields both set");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_axis_tready)
        else $error("request taken while previous one in work");
`endif

endmodule
